// ===== hw/rtl/jcm_pkg.sv =====
// Shared types, constants and table helpers for the jet colormap lookup.
// No dependencies; imported by jcm_fill, jcm_div and the top level.
package jcm_pkg;

    localparam int CFG_DATA_W = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int COLOR_W    = 8;
    localparam int RGB_W      = 3 * COLOR_W;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RANGE_LOW   = 2'd0,
        CFG_RANGE_HIGH  = 2'd1,
        CFG_INTERPOLATE = 2'd2
    } t_cfg_idx;

    localparam int CH_RED   = 0;
    localparam int CH_GREEN = 1;
    localparam int CH_BLUE  = 2;

    // Per-item flags that travel alongside the divider.
    typedef struct packed {
        logic interp;
        logic clamp;
        logic zero;
    } t_side;

    // Ramp numerator (0..n) of one channel of a jet map with m entries.
    // The level is round(255 * num / n), with n = ceil(m / 4).
    function automatic int jet_num(input int entry, input int ch, input int m);
        int n;
        int off;
        int shift;
        int k;
        int num;
        n     = (m + 3) / 4;
        off   = (n + 1) / 2 - ((m % 4 == 1) ? 1 : 0);
        shift = (ch == CH_RED) ? n : ((ch == CH_BLUE) ? -n : 0);
        k     = entry + 1 - off - shift;
        if (k < 1 || k > 3 * n - 1) begin
            num = 0;
        end else if (k <= n) begin
            num = k;
        end else if (k < 2 * n) begin
            num = n;
        end else begin
            num = 3 * n - k;
        end
        return num;
    endfunction

endpackage

// ===== hw/rtl/jcm_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module jcm_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== hw/rtl/jcm_fill.sv =====
// Loads the jet color table into the lookup RAM after reset, one row a cycle.
// Depends on jcm_pkg for the ramp function and color widths.
module jcm_fill
    import jcm_pkg::*;
#(
    parameter int TABLE_ENTRIES = 64
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    output logic                             o_wr_en,
    output logic [$clog2(TABLE_ENTRIES)-1:0] o_wr_addr,
    output logic [2*RGB_W-1:0]               o_wr_data,
    output logic                             o_busy
);

    localparam int AW = $clog2(TABLE_ENTRIES);
    localparam int JN = (TABLE_ENTRIES + 3) / 4;
    localparam logic [AW-1:0] LAST = AW'(TABLE_ENTRIES - 1);

    logic [RGB_W-1:0] w_tbl [TABLE_ENTRIES];

    for (genvar e = 0; e < TABLE_ENTRIES; e++) begin : g_tbl
        localparam int LR = (510 * jet_num(e, CH_RED, TABLE_ENTRIES) + JN) / (2 * JN);
        localparam int LG = (510 * jet_num(e, CH_GREEN, TABLE_ENTRIES) + JN) / (2 * JN);
        localparam int LB = (510 * jet_num(e, CH_BLUE, TABLE_ENTRIES) + JN) / (2 * JN);
        assign w_tbl[e] = {COLOR_W'(LR), COLOR_W'(LG), COLOR_W'(LB)};
    end

    logic [AW-1:0] r_addr;
    logic [AW-1:0] n_addr;
    logic          r_done;
    logic          n_done;
    logic [AW-1:0] w_next;

    // Each row holds an entry and its upper neighbor so one read feeds the blend.
    assign w_next = (r_addr == LAST) ? r_addr : r_addr + AW'(1);

    always_comb begin
        n_addr = r_addr;
        n_done = r_done;
        if (!r_done) begin
            if (r_addr == LAST) begin
                n_done = 1'b1;
            end else begin
                n_addr = r_addr + AW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_addr <= '0;
            r_done <= 1'b0;
        end else begin
            r_addr <= n_addr;
            r_done <= n_done;
        end
    end

    assign o_wr_en   = !r_done;
    assign o_wr_addr = r_addr;
    assign o_wr_data = {w_tbl[r_addr], w_tbl[w_next]};
    assign o_busy    = !r_done;

endmodule

// ===== hw/rtl/jcm_div.sv =====
// Pipelined restoring divider: one quotient bit per stage, one item per cycle.
// Depends on jcm_pkg for the sideband struct carried with each item.
module jcm_div
    import jcm_pkg::*;
#(
    parameter int DW = 33,
    parameter int QW = 14
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  logic [DW+QW-1:0] i_num,
    input  logic [DW-1:0]    i_den,
    input  t_side            i_side,
    output logic             o_valid,
    output logic [QW-1:0]    o_quot,
    output t_side            o_side
);

    localparam int RW = DW + QW;

    logic            r_vld  [QW];
    logic [RW-1:0]   r_rem  [QW];
    logic [DW-1:0]   r_den  [QW];
    logic [QW-1:0]   r_quot [QW];
    t_side           r_side [QW];

    for (genvar j = 0; j < QW; j++) begin : g_stage
        logic          w_vld;
        logic [RW-1:0] w_rem;
        logic [DW-1:0] w_den;
        logic [QW-1:0] w_quot;
        t_side         w_side;
        logic [RW-1:0] w_sub;
        logic          w_ge;
        logic [RW-1:0] n_rem;
        logic [QW-1:0] n_quot;

        if (j == 0) begin : g_first
            assign w_vld  = i_valid;
            assign w_rem  = i_num;
            assign w_den  = i_den;
            assign w_quot = '0;
            assign w_side = i_side;
        end else begin : g_rest
            assign w_vld  = r_vld[j-1];
            assign w_rem  = r_rem[j-1];
            assign w_den  = r_den[j-1];
            assign w_quot = r_quot[j-1];
            assign w_side = r_side[j-1];
        end

        // Stage j decides quotient bit QW-1-j against the divisor shifted to it.
        assign w_sub  = RW'(w_den) << (QW - 1 - j);
        assign w_ge   = (w_rem >= w_sub);
        assign n_rem  = w_ge ? (w_rem - w_sub) : w_rem;
        assign n_quot = w_quot | (QW'(w_ge) << (QW - 1 - j));

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[j] <= 1'b0;
            end else begin
                r_vld[j] <= w_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            r_rem[j]  <= n_rem;
            r_den[j]  <= w_den;
            r_quot[j] <= n_quot;
            r_side[j] <= w_side;
        end
    end

    assign o_valid = r_vld[QW-1];
    assign o_quot  = r_quot[QW-1];
    assign o_side  = r_side[QW-1];

endmodule

// ===== hw/rtl/jet_colormap_lookup.sv =====
// Top level of the jet colormap lookup: config registers, range front end,
// divider, table RAM and blend. Depends on jcm_pkg, jcm_ram, jcm_fill, jcm_div.
//
//   Port group   Direction  Handshake                    Payload
//   command      in         start (taken when !busy)     i_sample
//   result       out        o_valid, one-cycle strobe    o_red, o_green, o_blue, o_clamped
//   config       in         i_cfg_valid / o_cfg_ready    i_cfg_index, i_cfg_data
//
// One sample is taken every cycle while busy is low; each result passes through
// the front end, the divider with one quotient bit per stage, the table read and
// the blend, in that order. After reset busy stays high while the color table is
// written into the RAM; config writes are taken during that time.
// The result side has no back-pressure: every strobe is a completed transfer.
module jet_colormap_lookup
    import jcm_pkg::*;
#(
    parameter int TABLE_ENTRIES = 64,
    parameter int FRACTION_BITS = 8,
    parameter int SAMPLE_WIDTH  = 32
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    start,
    output logic                    busy,
    input  logic [SAMPLE_WIDTH-1:0] i_sample,
    output logic                    o_valid,
    output logic [COLOR_W-1:0]      o_red,
    output logic [COLOR_W-1:0]      o_green,
    output logic [COLOR_W-1:0]      o_blue,
    output logic                    o_clamped,
    input  logic                    i_cfg_valid,
    output logic                    o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [CFG_DATA_W-1:0]   i_cfg_data
);

    localparam int SW = SAMPLE_WIDTH;
    localparam int F  = FRACTION_BITS;
    localparam int DW = SW + 1;
    localparam int AW = $clog2(TABLE_ENTRIES);
    localparam int QW = AW + F;
    localparam int NW = DW + AW;
    localparam int RW = DW + QW;
    localparam logic [AW-1:0] LAST = AW'(TABLE_ENTRIES - 1);
    localparam logic [F:0]    ONE  = {1'b1, {F{1'b0}}};
    localparam logic [F+8:0]  HALF = (F+9)'(1) << (F - 1);

    // ---------------- Configuration registers ----------------
    logic [CFG_DATA_W-1:0] r_range_low;
    logic [CFG_DATA_W-1:0] r_range_high;
    logic                  r_interp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_range_low  <= CFG_DATA_W'(0);
            r_range_high <= CFG_DATA_W'(65535);
            r_interp     <= 1'b1;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_RANGE_LOW:   r_range_low  <= i_cfg_data;
                CFG_RANGE_HIGH:  r_range_high <= i_cfg_data;
                CFG_INTERPOLATE: r_interp     <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    assign o_cfg_ready = 1'b1;

    // ---------------- Table fill and RAM ----------------
    logic                  w_fill_busy;
    logic                  w_wr_en;
    logic [AW-1:0]         w_wr_addr;
    logic [2*RGB_W-1:0]    w_wr_data;
    logic [AW-1:0]         w_rd_addr;
    logic [2*RGB_W-1:0]    w_rd_data;

    jcm_fill #(
        .TABLE_ENTRIES(TABLE_ENTRIES)
    ) u_fill (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .o_wr_en  (w_wr_en),
        .o_wr_addr(w_wr_addr),
        .o_wr_data(w_wr_data),
        .o_busy   (w_fill_busy)
    );

    jcm_ram #(
        .WIDTH(2 * RGB_W),
        .DEPTH(TABLE_ENTRIES)
    ) u_ram (
        .i_clk    (i_clk),
        .i_wr_en  (w_wr_en),
        .i_wr_addr(w_wr_addr),
        .i_wr_data(w_wr_data),
        .i_rd_addr(w_rd_addr),
        .o_rd_data(w_rd_data)
    );

    assign busy = w_fill_busy;

    // ---------------- Stage 1: bounds in order, differences ----------------
    logic [CFG_DATA_W+SW-1:0] w_lo_wide;
    logic [CFG_DATA_W+SW-1:0] w_hi_wide;
    logic [SW-1:0]            w_lo_raw;
    logic [SW-1:0]            w_hi_raw;
    logic [SW-1:0]            w_lo;
    logic [SW-1:0]            w_hi;
    logic [DW-1:0]            w_lo_x;
    logic [DW-1:0]            w_hi_x;
    logic [DW-1:0]            w_s_x;
    logic                     w_accept;

    // Bounds are read as SAMPLE_WIDTH-bit two's complement values.
    assign w_lo_wide = {{SW{1'b0}}, r_range_low};
    assign w_hi_wide = {{SW{1'b0}}, r_range_high};
    assign w_lo_raw  = w_lo_wide[SW-1:0];
    assign w_hi_raw  = w_hi_wide[SW-1:0];
    assign w_lo      = ($signed(w_lo_raw) > $signed(w_hi_raw)) ? w_hi_raw : w_lo_raw;
    assign w_hi      = ($signed(w_lo_raw) > $signed(w_hi_raw)) ? w_lo_raw : w_hi_raw;
    assign w_lo_x    = {w_lo[SW-1], w_lo};
    assign w_hi_x    = {w_hi[SW-1], w_hi};
    assign w_s_x     = {i_sample[SW-1], i_sample};
    assign w_accept  = start && !w_fill_busy;

    logic          r_s1_vld;
    logic [DW-1:0] r_s1_den;
    logic [DW-1:0] r_s1_dpos;
    logic [DW-1:0] r_s1_dneg;
    logic          r_s1_interp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else begin
            r_s1_vld <= w_accept;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_den    <= w_hi_x - w_lo_x;
        r_s1_dpos   <= w_s_x - w_lo_x;
        r_s1_dneg   <= w_lo_x - w_s_x;
        r_s1_interp <= r_interp;
    end

    // ---------------- Stage 2: distance, range checks, scaled numerator ----------------
    logic [DW-1:0] w_d;
    logic [NW-1:0] w_prod;
    t_side         w_s2_side;

    // Samples below low mirror: the distance is taken as its magnitude.
    assign w_d    = r_s1_dpos[DW-1] ? r_s1_dneg : r_s1_dpos;
    assign w_prod = NW'(w_d) * NW'(TABLE_ENTRIES - 1);

    always_comb begin
        w_s2_side.interp = r_s1_interp;
        w_s2_side.zero   = (r_s1_den == '0);
        w_s2_side.clamp  = (r_s1_den == '0) || (w_d > r_s1_den);
    end

    logic          r_s2_vld;
    logic [RW-1:0] r_s2_num;
    logic [DW-1:0] r_s2_den;
    t_side         r_s2_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_vld <= 1'b0;
        end else begin
            r_s2_vld <= r_s1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s2_num  <= {w_prod, {F{1'b0}}};
        r_s2_den  <= r_s1_den;
        r_s2_side <= w_s2_side;
    end

    // ---------------- Divider ----------------
    logic          w_div_vld;
    logic [QW-1:0] w_quot;
    t_side         w_div_side;

    jcm_div #(
        .DW(DW),
        .QW(QW)
    ) u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(r_s2_vld),
        .i_num  (r_s2_num),
        .i_den  (r_s2_den),
        .i_side (r_s2_side),
        .o_valid(w_div_vld),
        .o_quot (w_quot),
        .o_side (w_div_side)
    );

    // ---------------- Table read ----------------
    logic [F-1:0] w_frac;

    always_comb begin
        if (w_div_side.zero) begin
            w_rd_addr = '0;
        end else if (w_div_side.clamp) begin
            w_rd_addr = LAST;
        end else begin
            w_rd_addr = w_quot[QW-1:F];
        end
    end

    // A zero fraction gives the lower entry unchanged, so it also covers truncation.
    assign w_frac = (w_div_side.interp && !w_div_side.clamp) ? w_quot[F-1:0] : '0;

    logic         r_bl_vld;
    logic [F-1:0] r_bl_frac;
    logic         r_bl_clamp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bl_vld <= 1'b0;
        end else begin
            r_bl_vld <= w_div_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_bl_frac  <= w_frac;
        r_bl_clamp <= w_div_side.clamp;
    end

    // ---------------- Blend ----------------
    logic [2:0][COLOR_W-1:0] w_c0;
    logic [2:0][COLOR_W-1:0] w_c1;
    logic [2:0][COLOR_W-1:0] n_rgb;
    logic [F:0]              w_wlo;

    assign w_c0  = w_rd_data[2*RGB_W-1:RGB_W];
    assign w_c1  = w_rd_data[RGB_W-1:0];
    assign w_wlo = ONE - {1'b0, r_bl_frac};

    always_comb begin
        logic [F+8:0] acc;
        for (int ch = 0; ch < 3; ch++) begin
            acc = (F+9)'(w_c0[ch]) * (F+9)'(w_wlo)
                + (F+9)'(w_c1[ch]) * (F+9)'(r_bl_frac)
                + HALF;
            n_rgb[ch] = acc[F+7:F];
        end
    end

    logic                    r_out_vld;
    logic [2:0][COLOR_W-1:0] r_rgb;
    logic                    r_clamped;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else begin
            r_out_vld <= r_bl_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rgb     <= n_rgb;
        r_clamped <= r_bl_clamp;
    end

    assign o_valid   = r_out_vld;
    assign o_red     = r_rgb[2];
    assign o_green   = r_rgb[1];
    assign o_blue    = r_rgb[0];
    assign o_clamped = r_clamped;

endmodule
